// ===== rtl/core/bdil_pkg.sv =====
// Shared constants, types and helper functions for the binary dilation core.
package bdil_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int RADIUS       = 2;
   localparam int HEIGHT_LIMIT = 1024;

   localparam int SPAN  = 2 * RADIUS + 1;
   localparam int KEPT  = 2 * RADIUS;
   localparam int NRES  = RADIUS + 1;

   localparam int PIX_W = 8;
   localparam int CFG_W = 11;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int HGT_W = $clog2(HEIGHT_LIMIT);
   localparam int ROW_W = $clog2(HEIGHT_LIMIT + RADIUS);

   // a line-end burst plus room for two more columns, so a receiver that
   // keeps pace never sees req_ready drop
   localparam int QDEPTH = 1 << $clog2(3 * NRES + 1);
   localparam int QA_W   = $clog2(QDEPTH);
   localparam int QC_W   = $clog2(QDEPTH + 1);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0]     CFG_RESET        = 11'd1024;

   typedef struct packed {
      logic [COL_W-1:0] w_m1;
      logic [HGT_W-1:0] h_m1;
   } cfg_type;

   // One vertical OR column leaving the line-buffer stage.
   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] vor;
      logic [COL_W-1:0] col;
      logic             at_last;
      logic             row_ok;
      logic             frame_row;
   } column_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             last_in_line;
      logic             last_in_frame;
   } rsp_type;

   function automatic logic [COL_W-1:0] eff_width_m1(input logic [CFG_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > 32'(MAX_WIDTH)) begin
         r = COL_W'(MAX_WIDTH - 1);
      end else begin
         r = COL_W'(v - CFG_W'(1));
      end
      return r;
   endfunction

   function automatic logic [HGT_W-1:0] eff_height_m1(input logic [CFG_W-1:0] v);
      logic [HGT_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > 32'(HEIGHT_LIMIT)) begin
         r = HGT_W'(HEIGHT_LIMIT - 1);
      end else begin
         r = HGT_W'(v - CFG_W'(1));
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/bdil_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module bdil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/core/bdil_column.sv =====
// Position tracking, four-row line buffer and vertical OR of one column.
module bdil_column (
   input  logic                      clock,
   input  logic                      reset,
   input  bdil_pkg::cfg_type         cfg,
   input  logic                      restart,
   input  logic                      accept,
   input  logic [bdil_pkg::PIX_W-1:0] pixel,
   input  logic                      pad,
   output bdil_pkg::column_type      col
);

   logic [bdil_pkg::COL_W-1:0] col_pos_ff, col_pos_in, c_now;
   logic [bdil_pkg::ROW_W-1:0] row_pos_ff, row_pos_in, frame_end;
   logic                       at_last, below;
   logic [bdil_pkg::PIX_W-1:0] cur_now;
   logic [bdil_pkg::KEPT-1:0]  mask_now;

   logic                       s1_valid_ff;
   logic [bdil_pkg::PIX_W-1:0] s1_cur_ff;
   logic [bdil_pkg::COL_W-1:0] s1_col_ff;
   logic [bdil_pkg::KEPT-1:0]  s1_mask_ff;
   logic                       s1_last_ff, s1_row_ok_ff, s1_frame_ff;

   logic                                          fwd_ff;
   logic [bdil_pkg::KEPT-1:0][bdil_pkg::PIX_W-1:0] fwd_word_ff;
   logic [bdil_pkg::KEPT-1:0][bdil_pkg::PIX_W-1:0] rd_word, old_word, new_word;
   logic [bdil_pkg::PIX_W-1:0]                     vor;

   always_comb begin
      c_now     = (col_pos_ff > cfg.w_m1) ? cfg.w_m1 : col_pos_ff;
      at_last   = (c_now == cfg.w_m1);
      frame_end = bdil_pkg::ROW_W'(cfg.h_m1) + bdil_pkg::ROW_W'(bdil_pkg::RADIUS);
      below     = (row_pos_ff > bdil_pkg::ROW_W'(cfg.h_m1));
      cur_now   = (pad || below) ? '0 : pixel;
      for (int k = 0; k < bdil_pkg::KEPT; k++) begin
         mask_now[k] = (row_pos_ff >= bdil_pkg::ROW_W'(k + 1));
      end

      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (restart) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end else if (accept) begin
         if (at_last) begin
            col_pos_in = '0;
            row_pos_in = (row_pos_ff >= frame_end) ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = c_now + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         s1_valid_ff <= accept;
         // width-one rows read the column that is being written this cycle
         fwd_ff      <= accept && s1_valid_ff && (c_now == s1_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      fwd_word_ff <= new_word;
      if (accept) begin
         s1_cur_ff    <= cur_now;
         s1_col_ff    <= c_now;
         s1_mask_ff   <= mask_now;
         s1_last_ff   <= at_last;
         s1_row_ok_ff <= (row_pos_ff >= bdil_pkg::ROW_W'(bdil_pkg::RADIUS));
         s1_frame_ff  <= (row_pos_ff == frame_end);
      end
   end

   // word slot k holds the pixel from k+1 rows above
   always_comb begin
      old_word    = fwd_ff ? fwd_word_ff : rd_word;
      new_word[0] = s1_cur_ff;
      vor         = s1_cur_ff;
      for (int k = 1; k < bdil_pkg::KEPT; k++) begin
         new_word[k] = old_word[k-1];
      end
      for (int k = 0; k < bdil_pkg::KEPT; k++) begin
         if (s1_mask_ff[k]) begin
            vor = vor | old_word[k];
         end
      end
   end

   bdil_ram #(
      .WIDTH (bdil_pkg::PIX_W * bdil_pkg::KEPT),
      .DEPTH (bdil_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (new_word),
      .rd_addr (c_now),
      .rd_data (rd_word)
   );

   assign col.valid     = s1_valid_ff;
   assign col.vor       = vor;
   assign col.col       = s1_col_ff;
   assign col.at_last   = s1_last_ff;
   assign col.row_ok    = s1_row_ok_ff;
   assign col.frame_row = s1_frame_ff;

endmodule

// ===== rtl/core/bdil_window.sv =====
// Five-column window of vertical ORs and result generation per column.
module bdil_window (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      restart,
   input  bdil_pkg::column_type                      col,
   output logic [bdil_pkg::NRES-1:0]                 push_valid,
   output bdil_pkg::rsp_type [bdil_pkg::NRES-1:0]    push_data
);

   logic [bdil_pkg::SPAN-1:0][bdil_pkg::PIX_W-1:0] window_ff, window_in;
   logic                                           line_start;

   always_comb begin
      line_start   = (col.col == '0);
      window_in[0] = col.vor;
      for (int i = 1; i < bdil_pkg::SPAN; i++) begin
         window_in[i] = line_start ? '0 : window_ff[i-1];
      end
      // result m is the output m columns right of the normal one; only at line end
      for (int m = 0; m < bdil_pkg::NRES; m++) begin
         push_data[m].out_pixel = '0;
         for (int t = 0; t < bdil_pkg::SPAN - m; t++) begin
            push_data[m].out_pixel = push_data[m].out_pixel | window_in[t];
         end
         push_data[m].last_in_line  = (m == bdil_pkg::RADIUS);
         push_data[m].last_in_frame = (m == bdil_pkg::RADIUS) && col.frame_row;
         push_valid[m] = col.valid && col.row_ok && ((m == 0) || col.at_last) &&
                         (32'(col.col) + 32'(m) >= 32'(bdil_pkg::RADIUS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         window_ff <= '0;
      end else if (col.valid) begin
         window_ff <= window_in;
      end
   end

endmodule

// ===== rtl/core/bdil_queue.sv =====
// Result queue: up to NRES pushes per cycle, one pop per cycle.
module bdil_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [bdil_pkg::NRES-1:0]              push_valid,
   input  bdil_pkg::rsp_type [bdil_pkg::NRES-1:0] push_data,
   input  logic                                   pop,
   output bdil_pkg::rsp_type                      head,
   output logic [bdil_pkg::QC_W-1:0]              count
);

   bdil_pkg::rsp_type              entries_ff [bdil_pkg::QDEPTH];
   logic [bdil_pkg::QA_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [bdil_pkg::QC_W-1:0]      count_ff, count_in, acc;
   logic [bdil_pkg::QA_W-1:0]      off [bdil_pkg::NRES];

   // pack the enabled results into consecutive slots
   always_comb begin
      acc = '0;
      for (int m = 0; m < bdil_pkg::NRES; m++) begin
         off[m] = bdil_pkg::QA_W'(acc);
         acc    = acc + bdil_pkg::QC_W'(push_valid[m]);
      end
      wr_ptr_in = wr_ptr_ff + bdil_pkg::QA_W'(acc);
      rd_ptr_in = rd_ptr_ff + bdil_pkg::QA_W'(pop);
      count_in  = count_ff + acc - bdil_pkg::QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < bdil_pkg::NRES; m++) begin
         if (push_valid[m]) begin
            entries_ff[bdil_pkg::QA_W'(wr_ptr_ff + off[m])] <= push_data[m];
         end
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// ===== rtl/core/binary_dilation_5x5_core.sv =====
// Top level of the streaming 5x5 square binary/grey dilation core.
//
// Usage:
//   req_*  : one 8-bit pixel per request in raster order. After the last image row
//            send 2*width requests with req_pad set to flush the final rows.
//   rsp_*  : output pixels in raster order; each is the OR of its 5x5 neighborhood
//            (outside the image counts as zero). last_in_line / last_in_frame tag
//            the final pixel of a row / of the frame.
//   csr_*  : index 0 = image width, 1 = image height (1..1024, clamped). A write
//            restarts the frame; write only while the core is idle.
// Path: the request that completes a result is registered in the column stage
//   (line-buffer read), then window/OR writes the result into the queue register.
// Throughput: one request per cycle; req_ready stays high if rsp_ready stays
//   high. A row's last column yields up to three results, draining one per cycle
//   from a 16-entry queue while the next row's first two columns yield none.
// Reset: positions, window and queue clear; width and height return to 1024.
//   Line-buffer contents are not cleared; rows above the image are masked.
// Stall: if rsp_ready stays low, the queue fills and req_ready drops; nothing is
//   lost, and req_ready depends only on internal state.
module binary_dilation_5x5_core (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bdil_pkg::PIX_W-1:0]      req_pixel,
   input  logic                            req_pad,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bdil_pkg::PIX_W-1:0]      rsp_out_pixel,
   output logic                            rsp_last_in_line,
   output logic                            rsp_last_in_frame,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bdil_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdil_pkg::CFG_W-1:0]      csr_wdata
);

   bdil_pkg::cfg_type                       cfg_ff, cfg_in;
   bdil_pkg::column_type                    col;
   bdil_pkg::rsp_type                       head;
   bdil_pkg::rsp_type [bdil_pkg::NRES-1:0]  push_data;
   logic [bdil_pkg::NRES-1:0]               push_valid;
   logic [bdil_pkg::QC_W-1:0]               count;
   logic [bdil_pkg::QC_W:0]                 need;
   logic                                    accept, pop, restart;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;
   assign restart   = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (restart) begin
         unique case (csr_index)
            bdil_pkg::CSR_IMAGE_WIDTH:  cfg_in.w_m1 = bdil_pkg::eff_width_m1(csr_wdata);
            bdil_pkg::CSR_IMAGE_HEIGHT: cfg_in.h_m1 = bdil_pkg::eff_height_m1(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.w_m1 <= bdil_pkg::eff_width_m1(bdil_pkg::CFG_RESET);
         cfg_ff.h_m1 <= bdil_pkg::eff_height_m1(bdil_pkg::CFG_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------- handshake
   // Room for the results of the column in flight plus the next request.
   always_comb begin
      need = (bdil_pkg::QC_W + 1)'(count) +
             (col.valid ? (bdil_pkg::QC_W + 1)'(bdil_pkg::NRES) : '0);
   end
   assign req_ready = (need <= (bdil_pkg::QC_W + 1)'(bdil_pkg::QDEPTH - bdil_pkg::NRES));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count != '0);
   assign pop       = rsp_valid && rsp_ready;

   // -------------------------------------------------------------- datapath
   bdil_column u_column (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .restart (restart),
      .accept  (accept),
      .pixel   (req_pixel),
      .pad     (req_pad),
      .col     (col)
   );

   bdil_window u_window (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .col        (col),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   bdil_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .count      (count)
   );

   assign rsp_out_pixel     = head.out_pixel;
   assign rsp_last_in_line  = head.last_in_line;
   assign rsp_last_in_frame = head.last_in_frame;

   // ------------------------------------------------------------ assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count) <= 32'(bdil_pkg::QDEPTH))
      else $error("result queue overflow");

   a_frame_ends_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_in_frame) |-> rsp_last_in_line)
      else $error("frame end without line end");

   a_accept_reaches_column: assert property (@(posedge clock) disable iff (reset)
      accept |=> col.valid)
      else $error("accepted request lost before column stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

// ===== tb/binary_dilation_5x5_core_tb.sv =====
// Self-checking testbench for the streaming 5x5 dilation core.
`timescale 1ns / 100ps

module binary_dilation_5x5_core_tb;
   import bdil_pkg::*;

   localparam int HIST_ROWS    = 4;    // rows of history the window reaches back over
   localparam int SETTLE       = 10;   // cycles of quiet before a register write
   localparam int RANDOM_ITEMS = 435;
   localparam int QUIET_TAIL   = 60;   // last random requests run with no idling

   // One row of the directed plan: a register write, or a request whose
   // results are either typed in here (typed) or left to the predictor.
   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_e;

   typedef struct packed {
      row_kind_e            kind;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [CFG_W-1:0]     reg_val;
      logic [PIX_W-1:0]     pixel;
      logic                 pad;
      logic                 typed;
      logic                 one_rsp;
      rsp_type              rsp;
   } plan_row_t;

   localparam rsp_type NO_RSP = '0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel = '0;
   logic                 req_pad = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PIX_W-1:0]     rsp_out_pixel;
   logic                 rsp_last_in_line;
   logic                 rsp_last_in_frame;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // Predictor state: register copies, frame position, line history and the
   // vertical-OR column window.
   logic [CFG_W-1:0]     width_reg = CFG_RESET;
   logic [CFG_W-1:0]     height_reg = CFG_RESET;
   int                   in_row = 0;
   int                   in_col = 0;
   logic [PIX_W-1:0]     row_hist [0:HIST_ROWS*MAX_WIDTH-1];
   logic [PIX_W-1:0]     vert_or [0:SPAN-1];

   rsp_type              pending_pixels [$];  // expected results, oldest first
   rsp_type              fresh [$];           // results of the latest request
   rsp_type              want;
   int                   mismatches = 0;
   int                   random_sent = 0;
   bit                   quiet = 1'b0;        // no idling on either side
   bit                   steady = 1'b0;       // a phase with no idling

   // Directed part. Typed rows (reset-size start, tiny frames) have an obvious
   // outcome: a 1x1 image sees one result, on its third request, with both tags.
   plan_row_t directed_plan [0:24] = '{
      // reset size 1024x1024: nothing comes out this early
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h00, 1'b1, 1'b1, 1'b0, NO_RSP},
      // 1x1 frame
      '{ROW_CSR,   CSR_IMAGE_WIDTH,  11'd1, 8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_CSR,   CSR_IMAGE_HEIGHT, 11'd1, 8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h00, 1'b1, 1'b1, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h3C, 1'b1, 1'b1, 1'b1,
        '{8'hFF, 1'b1, 1'b1}},
      // next frame: pad inside the image, then a live pixel in a pad row
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h81, 1'b1, 1'b1, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h7E, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h00, 1'b1, 1'b1, 1'b1,
        '{8'h00, 1'b1, 1'b1}},
      // zero width and height behave as one
      '{ROW_CSR,   CSR_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_CSR,   CSR_IMAGE_HEIGHT, 11'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h5A, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h00, 1'b1, 1'b1, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'hC3, 1'b1, 1'b1, 1'b1,
        '{8'h5A, 1'b1, 1'b1}},
      // 2x2 frame, checked by the predictor
      '{ROW_CSR,   CSR_IMAGE_WIDTH,  11'd2, 8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_CSR,   CSR_IMAGE_HEIGHT, 11'd2, 8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h01, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h80, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h10, 1'b1, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h42, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b1, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h99, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'h00, 1'b1, 1'b0, 1'b0, NO_RSP},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  11'd0, 8'hE7, 1'b1, 1'b0, 1'b0, NO_RSP}
   };

   binary_dilation_5x5_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .req_pad           (req_pad),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_last_in_line  (rsp_last_in_line),
      .rsp_last_in_frame (rsp_last_in_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Out-of-range sizes: zero acts as one, anything past the top as the top.
   function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int top);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > top) begin
         return top;
      end
      return int'(v);
   endfunction

   // Advance the predictor by one request; results land in fresh.
   task automatic dilate_pixel(input logic [PIX_W-1:0] pixel, input logic pad);
      int               w;
      int               h;
      int               r;
      int               c;
      int               col;
      int               last_m;
      logic [PIX_W-1:0] cur;
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] y;
      rsp_type          res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, HEIGHT_LIMIT);
      r = in_row;
      c = in_col;
      if (c >= w) c = w - 1;
      // pad requests and anything below the image read as zero
      cur = (pad || r >= h) ? '0 : pixel;
      if (c == 0) begin
         for (int k = 0; k < SPAN; k++) vert_or[k] = '0;
      end
      // vertical OR down the column; rows above the image are masked out
      v = cur;
      for (int k = 1; k <= KEPT; k++) begin
         if (r >= k) v |= row_hist[((r - k) % HIST_ROWS) * MAX_WIDTH + c];
      end
      row_hist[(r % HIST_ROWS) * MAX_WIDTH + c] = cur;
      for (int k = SPAN - 1; k >= 1; k--) vert_or[k] = vert_or[k - 1];
      vert_or[0] = v;
      // the last column also flushes the two outputs right of center
      last_m = (c == w - 1) ? RADIUS : 0;
      if (r >= RADIUS) begin
         for (int m = 0; m <= last_m; m++) begin
            col = c - RADIUS + m;
            if (col >= 0) begin
               y = '0;
               for (int t = 0; t <= 2 * RADIUS - m; t++) y |= vert_or[t];
               res.out_pixel     = y;
               res.last_in_line  = (col == w - 1);
               res.last_in_frame = (col == w - 1) && (r == h - 1 + RADIUS);
               fresh.push_back(res);
            end
         end
      end
      if (c == w - 1) begin
         in_col = 0;
         in_row = (r >= h - 1 + RADIUS) ? 0 : r + 1;
      end else begin
         in_col = c + 1;
         in_row = r;
      end
   endtask

   // Register writes wait until the core has drained, then restart the frame.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) begin
         width_reg = val;
      end else begin
         height_reg = val;
      end
      in_row = 0;
      in_col = 0;
      for (int k = 0; k < SPAN; k++) vert_or[k] = '0;
   endtask

   // One request. Valid stays up across back-to-back requests; it drops for an idle
   // burst, and also before register writes and at the end of the run.
   task automatic send_pixel(input logic [PIX_W-1:0] pixel, input logic pad,
                             input logic typed, input logic one_rsp,
                             input rsp_type typed_rsp);
      if (!quiet && !steady && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      req_pad   <= pad;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fresh.delete();
      dilate_pixel(pixel, pad);
      if (typed) begin
         if (one_rsp) pending_pixels.push_back(typed_rsp);
      end else begin
         foreach (fresh[i]) pending_pixels.push_back(fresh[i]);
      end
   endtask

   // Sparse pixels keep the OR of 25 neighbors from saturating to all ones.
   function automatic logic [PIX_W-1:0] sparse_pixel();
      case ($urandom_range(0, 19))
         0, 1, 2:       return PIX_W'($urandom_range(0, 255));
         3, 4, 5, 6, 7: return PIX_W'(1 << $urandom_range(0, PIX_W - 1));
         default:       return '0;
      endcase
   endfunction

   // Image rows (rare pads inside), then the 2*width flush requests (mostly
   // pad, some live pixels that must read as zero). A broken frame stops early,
   // and so does any frame once the random budget is spent.
   task automatic stream_frame(input int w, input int h, input bit broken);
      int total;
      int stop;
      total = w * h + RADIUS * w;
      stop  = broken ? $urandom_range(1, total - 1) : total;
      for (int i = 0; i < stop; i++) begin
         if (random_sent >= RANDOM_ITEMS) break;
         if (i < w * h) begin
            send_pixel(sparse_pixel(), $urandom_range(0, 15) == 0, 1'b0, 1'b0, NO_RSP);
         end else begin
            send_pixel(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 5) != 0,
                       1'b0, 1'b0, NO_RSP);
         end
         random_sent++;
      end
   endtask

   // Main sequence: reset, directed plan, random phases.
   initial begin
      logic [CFG_W-1:0] wv;
      logic [CFG_W-1:0] hv;
      int               nframes;
      bit               broken;
      for (int i = 0; i < HIST_ROWS * MAX_WIDTH; i++) row_hist[i] = '0;
      for (int k = 0; k < SPAN; k++) vert_or[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            write_csr(directed_plan[i].reg_idx, directed_plan[i].reg_val);
         end else begin
            send_pixel(directed_plan[i].pixel, directed_plan[i].pad,
                       directed_plan[i].typed, directed_plan[i].one_rsp,
                       directed_plan[i].rsp);
         end
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         quiet  = (random_sent >= RANDOM_ITEMS - QUIET_TAIL);
         steady = !quiet && ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0:       wv = '0;
            1, 2:    wv = CFG_W'($urandom_range(13, 40));
            default: wv = CFG_W'($urandom_range(1, 12));
         endcase
         hv = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
         if ($urandom_range(0, 1) == 0) begin
            write_csr(CSR_IMAGE_WIDTH, wv);
            write_csr(CSR_IMAGE_HEIGHT, hv);
         end else begin
            write_csr(CSR_IMAGE_HEIGHT, hv);
            write_csr(CSR_IMAGE_WIDTH, wv);
         end
         // back-to-back frames exercise the wrap at frame end
         nframes = $urandom_range(1, 3);
         for (int f = 0; f < nframes; f++) begin
            broken = ($urandom_range(0, 7) == 0);
            stream_frame(clamp_dim(wv, MAX_WIDTH), clamp_dim(hv, HEIGHT_LIMIT), broken);
            if (broken) break;
         end
      end

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver: ready in random stretches with stall bursts between them outside quiet and steady phases.
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet && !steady) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            $error("out_pixel: expected none, got %h", rsp_out_pixel);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_pixel !== want.out_pixel) begin
               mismatches++;
               $error("out_pixel: expected %h, got %h", want.out_pixel, rsp_out_pixel);
            end
            if (rsp_last_in_line !== want.last_in_line) begin
               mismatches++;
               $error("last_in_line: expected %b, got %b",
                      want.last_in_line, rsp_last_in_line);
            end
            if (rsp_last_in_frame !== want.last_in_frame) begin
               mismatches++;
               $error("last_in_frame: expected %b, got %b",
                      want.last_in_frame, rsp_last_in_frame);
            end
         end
      end
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #8000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
